### rtl/sadm_pkg.sv
// ============================================================================
// sadm_pkg: shared types and constants of the sad template matcher
// pixel widths, gray conversion weights, register map and cell control bundle
// ============================================================================
package sadm_pkg;

    // default geometry, handed to the top level parameters
    localparam int DEF_TEMPLATE_HEIGHT = 8;
    localparam int DEF_TEMPLATE_WIDTH  = 8;
    localparam int DEF_IMAGE_WIDTH     = 512;

    // payload widths
    localparam int PIX_W    = 8;
    localparam int RGB_W    = 24;
    localparam int REQ_W    = 1;
    localparam int SUM_O_W  = 14;
    localparam int THRESH_W = 14;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TEMPLATE = 1'b0;
    localparam logic [REQ_W-1:0] REQ_IMAGE    = 1'b1;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = 3'd0;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd1024;
    localparam logic [SUM_O_W-1:0]  SUM_MAX      = 14'd16383;

    // luma weights, q16
    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;
    localparam int GRAY_SHIFT = 16;

    // per-cycle commands broadcast along the cell row
    typedef struct packed {
        logic shift;      // take the neighbor column
        logic rotate;     // rotate column and template, accumulate one difference
        logic acc_clear;  // restart the column sum
    } t_cell_ctrl;

    function automatic logic [PIX_W-1:0] to_gray(input logic [RGB_W-1:0] rgb);
        logic [RGB_W-1:0] y;
        y = RGB_W'(rgb[7:0])   * RGB_W'(COEF_R)
          + RGB_W'(rgb[15:8])  * RGB_W'(COEF_G)
          + RGB_W'(rgb[23:16]) * RGB_W'(COEF_B);
        return y[GRAY_SHIFT +: PIX_W];
    endfunction

endpackage

### rtl/sadm_in_if.sv
// ============================================================================
// sadm_in_if: pixel request channel
// valid/ready handshake carrying request type and rgb pixel
// ============================================================================
interface sadm_in_if import sadm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [RGB_W-1:0] rgb_pixel;

    modport source (output valid, output req_type, output rgb_pixel, input ready);
    modport sink   (input valid, input req_type, input rgb_pixel, output ready);
endinterface

### rtl/sadm_out_if.sv
// ============================================================================
// sadm_out_if: match result channel
// valid/ready handshake carrying match flag and difference sum
// ============================================================================
interface sadm_out_if import sadm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               match_flag;
    logic [SUM_O_W-1:0] difference_sum;

    modport source (output valid, output match_flag, output difference_sum, input ready);
    modport sink   (input valid, input match_flag, input difference_sum, output ready);
endinterface

### rtl/sad_template_match_stream.sv
// ============================================================================
// sad_template_match_stream: streaming sad template matcher
// rgb pixels become gray; template pixels load the template, image pixels
// slide a template-sized window and yield a sum of absolute differences
// ============================================================================
// sequence: an accepted image pixel passes S_SHIFT, S_ROWS (the row-serial
//   difference pass in each cell), S_REDUCE (the partial sum chain) and S_DONE,
//   where it waits for room in the output register; no new image pixel is taken
//   until the sequencer is back in S_IDLE, and template pixels are taken one per
//   cycle while it is idle
// reset: synchronous, active low; window cleared, threshold 1024, column and
//   template index zero; the line ram is masked as zero until its first row is written
module sad_template_match_stream import sadm_pkg::*; #(
    parameter int TEMPLATE_HEIGHT = DEF_TEMPLATE_HEIGHT,
    parameter int TEMPLATE_WIDTH  = DEF_TEMPLATE_WIDTH,
    parameter int IMAGE_WIDTH     = DEF_IMAGE_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sadm_in_if.sink               i_pix,
    sadm_out_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int COLW   = TEMPLATE_HEIGHT * PIX_W;          // one packed window column
    localparam int SUM_W  = $clog2(TEMPLATE_HEIGHT * TEMPLATE_WIDTH * 255 + 1);
    localparam int CMP_W  = (SUM_W > SUM_O_W) ? SUM_W : SUM_O_W;
    localparam int POS_W  = $clog2(IMAGE_WIDTH);
    localparam int ROW_W  = $clog2(TEMPLATE_HEIGHT);
    localparam int TCOL_W = $clog2(TEMPLATE_WIDTH);
    localparam int MAX_HW = (TEMPLATE_HEIGHT > TEMPLATE_WIDTH) ? TEMPLATE_HEIGHT
                                                                : TEMPLATE_WIDTH;
    localparam int CNT_W  = $clog2(MAX_HW);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHIFT  = 5'b00010,
        S_ROWS   = 5'b00100,
        S_REDUCE = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [THRESH_W-1:0] r_threshold;
    logic                w_cfg_wr;

    // control
    logic [POS_W-1:0]  r_col, n_col;
    logic              r_first_row, n_first_row;   // line ram not yet written at r_col
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ROW_W-1:0]  r_tpl_row, n_tpl_row;
    logic [TCOL_W-1:0] r_tpl_col, n_tpl_col;
    logic              r_out_valid, n_out_valid;

    // payload
    logic [PIX_W-1:0]   r_gray;
    logic               r_out_flag;
    logic [SUM_O_W-1:0] r_out_sum;

    logic [PIX_W-1:0] w_gray;
    logic             w_in_acc;
    logic             w_tpl_acc;
    logic             w_img_acc;
    logic             w_out_load;
    logic [COLW-1:0]  w_ram_rdata;
    logic [COLW-1:0]  w_new_col;
    logic [CMP_W-1:0] w_sum_ext;
    t_cell_ctrl       w_ctrl;

    // cell row wiring: column of cell j+1 feeds cell j, partial sums move toward cell 0
    logic [COLW-1:0]  w_col  [TEMPLATE_WIDTH + 1];
    logic [SUM_W-1:0] w_part [TEMPLATE_WIDTH + 1];
    logic             w_tpl_we [TEMPLATE_WIDTH];

    // ------------------------------------------------------------------
    // configuration port, register written in the access phase
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (w_cfg_wr) begin
            r_threshold <= pwdata[THRESH_W-1:0];
        end
    end

    always_comb begin
        if (paddr[PADDR_W-1] == ADDR_THRESHOLD[PADDR_W-1]) begin
            prdata = APB_DATA_W'(r_threshold);
        end else begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // input transaction and gray conversion
    // ------------------------------------------------------------------
    assign i_pix.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_pix.valid && i_pix.ready;
    assign w_tpl_acc   = w_in_acc && (i_pix.req_type == REQ_TEMPLATE);
    assign w_img_acc   = w_in_acc && (i_pix.req_type == REQ_IMAGE);
    assign w_gray      = to_gray(i_pix.rgb_pixel);

    always_ff @(posedge i_clk) begin
        if (w_img_acc) begin
            r_gray <= w_gray;
        end
    end

    // ------------------------------------------------------------------
    // line ram: one word per image column, holding the column history
    // read runs continuously at r_col, so the word is ready in S_SHIFT
    // ------------------------------------------------------------------
    sadm_ram #(
        .WIDTH (COLW),
        .DEPTH (IMAGE_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_SHIFT),
        .i_waddr (r_col),
        .i_wdata (w_new_col),
        .i_raddr (r_col),
        .o_rdata (w_ram_rdata)
    );

    // oldest row drops off the top, new gray enters the bottom row
    always_comb begin
        if (r_first_row) begin
            w_new_col = {r_gray, {(COLW - PIX_W){1'b0}}};
        end else begin
            w_new_col = {r_gray, w_ram_rdata[COLW-1:PIX_W]};
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_first_row = r_first_row;
        n_cnt       = r_cnt;
        n_tpl_row   = r_tpl_row;
        n_tpl_col   = r_tpl_col;
        n_out_valid = r_out_valid;
        w_ctrl      = '0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // template index walks in raster order and wraps at the last entry
                if (w_tpl_acc) begin
                    if (r_tpl_col == TCOL_W'(TEMPLATE_WIDTH - 1)) begin
                        n_tpl_col = '0;
                        if (r_tpl_row == ROW_W'(TEMPLATE_HEIGHT - 1)) begin
                            n_tpl_row = '0;
                        end else begin
                            n_tpl_row = r_tpl_row + 1'b1;
                        end
                    end else begin
                        n_tpl_col = r_tpl_col + 1'b1;
                    end
                end
                if (w_img_acc) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                w_ctrl.shift     = 1'b1;
                w_ctrl.acc_clear = 1'b1;
                n_cnt            = '0;
                if (r_col == POS_W'(IMAGE_WIDTH - 1)) begin
                    n_col       = '0;
                    n_first_row = 1'b0;
                end else begin
                    n_col = r_col + 1'b1;
                end
                n_state = S_ROWS;
            end
            S_ROWS: begin
                // one row difference per cell per cycle
                w_ctrl.rotate = 1'b1;
                if (r_cnt == CNT_W'(TEMPLATE_HEIGHT - 1)) begin
                    n_cnt   = '0;
                    n_state = S_REDUCE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_REDUCE: begin
                // partial sums pass through the partial sum register of each cell on their way to cell 0
                if (r_cnt == CNT_W'(TEMPLATE_WIDTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                // wait for room in the output register
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_first_row <= 1'b1;
            r_cnt       <= '0;
            r_tpl_row   <= '0;
            r_tpl_col   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_first_row <= n_first_row;
            r_cnt       <= n_cnt;
            r_tpl_row   <= n_tpl_row;
            r_tpl_col   <= n_tpl_col;
            r_out_valid <= n_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // row of window cells, cell 0 is the left window edge
    // ------------------------------------------------------------------
    assign w_col[TEMPLATE_WIDTH]  = w_new_col;
    assign w_part[TEMPLATE_WIDTH] = '0;

    for (genvar j = 0; j < TEMPLATE_WIDTH; j++) begin : g_cell
        assign w_tpl_we[j] = w_tpl_acc && (r_tpl_col == TCOL_W'(j));

        sadm_cell #(
            .HEIGHT (TEMPLATE_HEIGHT),
            .SUM_W  (SUM_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_col     (w_col[j+1]),
            .o_col     (w_col[j]),
            .i_tpl_we  (w_tpl_we[j]),
            .i_tpl_row (r_tpl_row),
            .i_tpl_pix (w_gray),
            .i_partial (w_part[j+1]),
            .o_partial (w_part[j])
        );
    end

    // ------------------------------------------------------------------
    // output register: flag from the full sum, reported sum saturates
    // ------------------------------------------------------------------
    assign w_sum_ext = CMP_W'(w_part[0]);

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_flag <= (w_sum_ext <= CMP_W'(r_threshold));
            if (w_sum_ext > CMP_W'(SUM_MAX)) begin
                r_out_sum <= SUM_MAX;
            end else begin
                r_out_sum <= w_sum_ext[SUM_O_W-1:0];
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.match_flag     = r_out_flag;
    assign o_res.difference_sum = r_out_sum;
endmodule

### rtl/sadm_ram.sv
// ============================================================================
// sadm_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ============================================================================
module sadm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/sadm_cell.sv
// ============================================================================
// sadm_cell: one window column of the matcher
// holds a window column and a template column, sums their differences
// row by row and adds its sum into the partial sum from the right neighbor
// ============================================================================
module sadm_cell import sadm_pkg::*; #(
    parameter int HEIGHT = DEF_TEMPLATE_HEIGHT,
    parameter int SUM_W  = 14,
    localparam int ROW_W  = $clog2(HEIGHT),
    localparam int COL_W  = HEIGHT * PIX_W,
    localparam int CSUM_W = $clog2(HEIGHT * 255 + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  logic [COL_W-1:0] i_col,
    output logic [COL_W-1:0] o_col,
    input  logic             i_tpl_we,
    input  logic [ROW_W-1:0] i_tpl_row,
    input  logic [PIX_W-1:0] i_tpl_pix,
    input  logic [SUM_W-1:0] i_partial,
    output logic [SUM_W-1:0] o_partial
);
    logic [PIX_W-1:0]  r_win [HEIGHT];
    logic [PIX_W-1:0]  r_tpl [HEIGHT];
    logic [CSUM_W-1:0] r_acc;
    logic [SUM_W-1:0]  r_partial;
    logic [PIX_W-1:0]  w_diff;

    assign w_diff = (r_win[0] > r_tpl[0]) ? (r_win[0] - r_tpl[0]) : (r_tpl[0] - r_win[0]);

    // window column, row 0 on top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HEIGHT; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_ctrl.shift) begin
            for (int k = 0; k < HEIGHT; k++) begin
                r_win[k] <= i_col[k*PIX_W +: PIX_W];
            end
        end else if (i_ctrl.rotate) begin
            for (int k = 0; k < HEIGHT - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[HEIGHT-1] <= r_win[0];
        end
    end

    // template column, rotates in step with the window
    always_ff @(posedge i_clk) begin
        if (i_tpl_we) begin
            r_tpl[i_tpl_row] <= i_tpl_pix;
        end else if (i_ctrl.rotate) begin
            for (int k = 0; k < HEIGHT - 1; k++) begin
                r_tpl[k] <= r_tpl[k+1];
            end
            r_tpl[HEIGHT-1] <= r_tpl[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clear) begin
            r_acc <= '0;
        end else if (i_ctrl.rotate) begin
            r_acc <= r_acc + CSUM_W'(w_diff);
        end
        r_partial <= SUM_W'(r_acc) + i_partial;
    end

    for (genvar k = 0; k < HEIGHT; k++) begin : g_col
        assign o_col[k*PIX_W +: PIX_W] = r_win[k];
    end

    assign o_partial = r_partial;
endmodule
